// ===== src/rme_pkg.sv =====
package rme_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STEPS = 16;
    localparam int PIPE_DEPTH = SQRT_STEPS + CORDIC_STAGES + 2;
    localparam int CW = 34;
    localparam int ZW = 28;
    localparam logic signed [ZW-1:0] HALF_PI_UNITS = 28'sd26353589;
    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;
    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 2'd0;
    localparam logic [14:0] THRESHOLD_RESET = 15'd1;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m10;
        logic signed [15:0] m20;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } matrix_t;

    typedef struct packed {
        logic signed [15:0] angle_first;
        logic signed [15:0] angle_second;
        logic signed [15:0] angle_third;
        logic is_singular;
    } euler_t;

    // One CORDIC lane: vector, accumulated angle and a zero-input flag.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic zero;
    } lane_t;

    typedef lane_t [2:0] lanes_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0: r = 28'sd13176795;
            1: r = 28'sd7778716;
            2: r = 28'sd4110060;
            3: r = 28'sd2086331;
            4: r = 28'sd1047214;
            5: r = 28'sd524117;
            6: r = 28'sd262123;
            7: r = 28'sd131069;
            default: r = ZW'(28'sd65536 >>> (i - 8));
        endcase
        return r;
    endfunction

endpackage

// ===== src/rme_stream_if.sv =====
interface rme_stream_if #(parameter type payload_t = logic);
    logic valid;
    logic ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/rme_sqrt_cell.sv =====
module rme_sqrt_cell
    import rme_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [4:0]  step,
    input  logic [33:0] rem_in,
    input  logic [16:0] root_in,
    input  matrix_t     mat_in,
    output logic [33:0] rem_reg,
    output logic [16:0] root_reg,
    output matrix_t     mat_reg
);
    // One digit of a restoring square root, most significant pair first.
    logic [33:0] trial;
    logic [33:0] rem_next;
    logic [16:0] root_next;
    logic [5:0]  sh;

    always_comb
    begin
        sh = 6'(2 * (SQRT_STEPS - 1 - 32'(step)));
        trial = {15'd0, root_in, 2'b01} << sh;
        if (rem_in >= trial)
        begin
            rem_next = rem_in - trial;
            root_next = {root_in[15:0], 1'b1};
        end
        else
        begin
            rem_next = rem_in;
            root_next = {root_in[15:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            root_reg <= root_next;
            mat_reg <= mat_in;
        end
    end
endmodule

// ===== src/rme_cordic_cell.sv =====
module rme_cordic_cell
    import rme_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  logic [4:0] step,
    input  lanes_t lanes_in,
    input  logic   sing_in,
    output lanes_t lanes_reg,
    output logic   sing_reg
);
    lanes_t lanes_next;
    logic signed [ZW-1:0] ang;

    always_comb
    begin
        ang = atan_entry(32'(step));
        for (int k = 0; k < 3; k++)
        begin
            lanes_next[k] = lanes_in[k];
            if (!lanes_in[k].y[CW-1])
            begin
                lanes_next[k].x = lanes_in[k].x + (lanes_in[k].y >>> step);
                lanes_next[k].y = lanes_in[k].y - (lanes_in[k].x >>> step);
                lanes_next[k].z = lanes_in[k].z + ang;
            end
            else
            begin
                lanes_next[k].x = lanes_in[k].x - (lanes_in[k].y >>> step);
                lanes_next[k].y = lanes_in[k].y + (lanes_in[k].x >>> step);
                lanes_next[k].z = lanes_in[k].z - ang;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
            sing_reg <= sing_in;
        end
    end
endmodule

// ===== src/rotation_matrix_to_euler.sv =====
// Channel   Direction  Payload                                     Handshake
// in_ch     sink       m00 m10 m20 m11 m12 m21 m22 (Q2.14)         valid/ready
// out_ch    source     angle_first/second/third (Q3.13), singular  valid/ready
// apb       slave      singular_threshold at byte address 0        psel/penable
//
// The block is a chain of cells: sixteen square-root cells form sy, one cell
// selects the operands and prefolds them, sixteen CORDIC cells run three atan2
// lanes side by side, and a final cell rounds and clamps. One transfer is taken
// per cycle while the chain advances. The whole chain advances together and
// halts while the output register holds a result that is not taken. Reset
// clears the valid bits and loads the threshold register with its reset
// value of 1.
module rotation_matrix_to_euler
    import rme_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rme_stream_if.sink   in_ch,
    rme_stream_if.source out_ch,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    logic [14:0] threshold_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic adv;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THRESHOLD) ? {17'd0, threshold_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_THRESHOLD)
            threshold_reg <= pwdata[14:0];
    end

    // The chain moves whenever the last stage is empty or being drained.
    assign adv = !valid_reg[PIPE_DEPTH-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = valid_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_ch.valid};
    end

    // Square-root chain. The sum of squares fits in 32 bits.
    logic [33:0] rem_c [SQRT_STEPS+1];
    logic [16:0] root_c [SQRT_STEPS+1];
    matrix_t mat_c [SQRT_STEPS+1];
    logic signed [31:0] sq0, sq1;

    assign sq0 = in_ch.data.m00 * in_ch.data.m00;
    assign sq1 = in_ch.data.m10 * in_ch.data.m10;
    assign rem_c[0] = 34'(unsigned'(sq0)) + 34'(unsigned'(sq1));
    assign root_c[0] = '0;
    assign mat_c[0] = in_ch.data;

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        rme_sqrt_cell u_cell (
            .clk(clk), .en(adv), .step(5'(g)),
            .rem_in(rem_c[g]), .root_in(root_c[g]), .mat_in(mat_c[g]),
            .rem_reg(rem_c[g+1]), .root_reg(root_c[g+1]), .mat_reg(mat_c[g+1])
        );
    end

    // Operand selection and the quadrant prefold.
    matrix_t mt;
    logic [16:0] sy;
    logic sing;
    logic signed [17:0] num [3];
    logic signed [17:0] den [3];
    lanes_t pre_next;
    lanes_t cl [CORDIC_STAGES+1];
    logic sc [CORDIC_STAGES+1];

    always_comb
    begin
        mt = mat_c[SQRT_STEPS];
        sy = root_c[SQRT_STEPS];
        sing = sy < {2'b00, threshold_reg};
        num[0] = sing ? -18'(mt.m12) : 18'(mt.m21);
        den[0] = sing ? 18'(mt.m11) : 18'(mt.m22);
        num[1] = 18'(mt.m10);
        den[1] = 18'(mt.m00);
        num[2] = -18'(mt.m20);
        den[2] = signed'({1'b0, sy});
        for (int k = 0; k < 3; k++)
        begin
            pre_next[k].zero = (num[k] == 0) && (den[k] == 0);
            pre_next[k].x = CW'(den[k]) <<< 12;
            pre_next[k].y = CW'(num[k]) <<< 12;
            pre_next[k].z = '0;
            if (den[k] < 0)
            begin
                if (num[k] >= 0)
                begin
                    pre_next[k].x = CW'(num[k]) <<< 12;
                    pre_next[k].y = -(CW'(den[k]) <<< 12);
                    pre_next[k].z = HALF_PI_UNITS;
                end
                else
                begin
                    pre_next[k].x = -(CW'(num[k]) <<< 12);
                    pre_next[k].y = CW'(den[k]) <<< 12;
                    pre_next[k].z = -HALF_PI_UNITS;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cl[0] <= pre_next;
            sc[0] <= sing;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        rme_cordic_cell u_cell (
            .clk(clk), .en(adv), .step(5'(g)),
            .lanes_in(cl[g]), .sing_in(sc[g]),
            .lanes_reg(cl[g+1]), .sing_reg(sc[g+1])
        );
    end

    // Round to Q3.13 and clamp, then register the result.
    logic signed [16:0] ang [3];
    logic signed [ZW-1:0] zr;
    euler_t res_next, res_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            zr = (cl[CORDIC_STAGES][k].z + ZW'(1024)) >>> 11;
            if (cl[CORDIC_STAGES][k].zero)
                ang[k] = '0;
            else if (zr > ZW'(ANGLE_LIMIT))
                ang[k] = 17'(ANGLE_LIMIT);
            else if (zr < -ZW'(ANGLE_LIMIT))
                ang[k] = -17'(ANGLE_LIMIT);
            else
                ang[k] = zr[16:0];
        end
        res_next.is_singular = sc[CORDIC_STAGES];
        res_next.angle_first = ang[0][15:0];
        res_next.angle_second = sc[CORDIC_STAGES] ? 16'sd0 : ang[1][15:0];
        res_next.angle_third = ang[2][15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign out_ch.data = res_reg;
endmodule
